// File: rtl/core/dht_pkg.sv
// Shared types and codes for the double hashing table.
// Used by double_hash_table; depends on nothing else.
`timescale 1ns / 1ps

package dht_pkg;

  localparam int unsigned KeyW   = 31;
  localparam int unsigned ValueW = 64;
  localparam int unsigned SlotW  = 7;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncSearch = 1'b1;

  typedef enum logic [2:0] {
    StInserted = 3'd0,
    StUpdated  = 3'd1,
    StFull     = 3'd2,
    StHit      = 3'd3,
    StMiss     = 3'd4
  } dht_status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SModSlots,
    SModStep,
    SModWrap,
    SRead,
    SCheck
  } dht_state_e;

  typedef struct packed {
    logic              func;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } dht_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ValueW-1:0] found_value;
    logic [SlotW-1:0]  slot_index;
  } dht_out_t;

  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } dht_slot_t;

endpackage

// File: rtl/core/double_hash_table.sv
// Open addressing hash table with double hashing, one probe unit under a sequencer.
// Depends on dht_pkg for payload structs, status codes and state encoding.
`timescale 1ns / 1ps

// Each transfer runs alone: after it is taken the block reduces the key mod
// TABLE_SLOTS, the key mod STEP_PRIME and the resulting step mod TABLE_SLOTS
// on one shared multiplier by reciprocal multiplication, each as operand
// times reciprocal, then quotient times divisor, then subtract. It then
// probes the slot memory, each probe a registered read and then a check and
// next-slot add, for at most TABLE_SLOTS probes. The result sits in an
// output register until it is taken; the next input can be taken in the same
// cycle as the result appears. The final check of an item waits while an
// earlier result still sits in the output register.
// After reset a clearing pass writes the TABLE_SLOTS slots in turn and marks
// every slot empty; no item is taken during it.
module double_hash_table
  import dht_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 101,
  parameter int unsigned STEP_PRIME  = 97
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dht_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dht_out_t out_data_o
);

  localparam int unsigned IdxW       = $clog2(TABLE_SLOTS);
  localparam int unsigned MagicW     = 32;
  localparam int unsigned ProdW      = KeyW + MagicW;
  localparam int unsigned SlotsShift = KeyW + $clog2(TABLE_SLOTS);
  localparam int unsigned StepShift  = KeyW + $clog2(STEP_PRIME);
  // floor(2^shift / d) + 1 gives the exact quotient for any KeyW-bit operand
  localparam logic [MagicW-1:0] SlotsMagic =
      MagicW'((64'd1 << SlotsShift) / 64'(TABLE_SLOTS) + 64'd1);
  localparam logic [MagicW-1:0] StepMagic =
      MagicW'((64'd1 << StepShift) / 64'(STEP_PRIME) + 64'd1);
  localparam logic [MagicW-1:0] SlotsDiv = MagicW'(TABLE_SLOTS);
  localparam logic [MagicW-1:0] StepDiv  = MagicW'(STEP_PRIME);
  localparam logic [KeyW-1:0]   StepKey  = KeyW'(STEP_PRIME);
  localparam logic [IdxW-1:0]   LastSlot = IdxW'(TABLE_SLOTS - 1);
  localparam logic [IdxW:0]     SlotsMod = (IdxW+1)'(TABLE_SLOTS);

  dht_state_e state_q, state_d;

  logic              func_q, func_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [KeyW-1:0]   div_q, div_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   step_q, step_d;
  logic [IdxW-1:0]   probe_q, probe_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  dht_out_t          res_q, res_d;

  // shared multiplier for the three reductions
  logic              use_step;
  logic [KeyW-1:0]   quo;
  logic [KeyW-1:0]   rem;
  logic [KeyW-1:0]   mul_a;
  logic [MagicW-1:0] mul_b;
  logic [ProdW-1:0]  mul_p;

  // next probe slot
  logic [IdxW:0] unit_x, unit_y;

  // slot memory
  dht_slot_t mem [TABLE_SLOTS];
  dht_slot_t rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  dht_slot_t       mem_wd;

  assign use_step = (state_q == SModStep);
  assign quo      = use_step ? KeyW'(prod_q >> StepShift) : KeyW'(prod_q >> SlotsShift);
  assign rem      = div_q - prod_q[KeyW-1:0];
  assign mul_a    = (cnt_q == 2'd0) ? div_q : quo;
  assign mul_b    = (cnt_q == 2'd0) ? (use_step ? StepMagic : SlotsMagic)
                                    : (use_step ? StepDiv : SlotsDiv);
  assign mul_p    = {MagicW'(0), mul_a} * {KeyW'(0), mul_b};

  assign unit_x = {1'b0, idx_q} + {1'b0, step_q};
  assign unit_y = (unit_x >= SlotsMod) ? (unit_x - SlotsMod) : unit_x;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    key_q   <= key_d;
    value_q <= value_d;
    div_q   <= div_d;
    prod_q  <= prod_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    step_q  <= step_d;
    probe_q <= probe_d;
    res_q   <= res_d;
  end

  always_comb begin
    logic     match;
    logic     out_free;
    logic     done;
    dht_out_t res_n;
    match       = rd_q.valid && (rd_q.key == key_q);
    out_free    = !out_valid_q || !out_stall_i;
    done        = 1'b0;
    res_n       = '0;
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    value_d     = value_q;
    div_d       = div_q;
    prod_d      = prod_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    step_d      = step_q;
    probe_d     = probe_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = '{valid: 1'b1, key: key_q, value: value_q};

    case (state_q)
      SClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (in_valid_i) begin
          func_d  = in_data_i.func;
          key_d   = in_data_i.key;
          value_d = in_data_i.value;
          div_d   = in_data_i.key;
          cnt_d   = '0;
          state_d = SModSlots;
        end
      end

      SModSlots, SModStep, SModWrap: begin
        prod_d = mul_p;
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          cnt_d = '0;
          case (state_q)
            SModSlots: begin
              idx_d   = rem[IdxW-1:0];
              div_d   = key_q;
              state_d = SModStep;
            end
            SModStep: begin
              div_d   = StepKey - rem;
              state_d = SModWrap;
            end
            default: begin
              step_d  = rem[IdxW-1:0];
              probe_d = '0;
              state_d = SRead;
            end
          endcase
        end
      end

      SRead: begin
        state_d = SCheck;
      end

      SCheck: begin
        done              = 1'b1;
        res_n.found_value = '0;
        res_n.slot_index  = SlotW'(idx_q);
        if (func_q == FuncInsert && (match || !rd_q.valid)) begin
          res_n.status = match ? StUpdated : StInserted;
        end else if (func_q == FuncSearch && !rd_q.valid) begin
          res_n.status     = StMiss;
          res_n.slot_index = '0;
        end else if (func_q == FuncSearch && match) begin
          res_n.status      = StHit;
          res_n.found_value = rd_q.value;
        end else if (probe_q == LastSlot) begin
          // every slot on the path tried
          res_n.status     = (func_q == FuncInsert) ? StFull : StMiss;
          res_n.slot_index = '0;
        end else begin
          done = 1'b0;
        end

        if (!done) begin
          idx_d   = unit_y[IdxW-1:0];
          probe_d = probe_q + 1'b1;
          state_d = SRead;
        end else if (out_free) begin
          // hold here while an earlier result still waits
          mem_we      = (func_q == FuncInsert) && (match || !rd_q.valid);
          res_d       = res_n;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule
